@@ hw/rtl/tape_image_pulse_decoder_unit_macros.svh @@
// assertion macros shared by the tape pulse decoder queue and back end modules
`ifndef TAPE_IMAGE_PULSE_DECODER_UNIT_MACROS_SVH
`define TAPE_IMAGE_PULSE_DECODER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define TIPD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TIPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define TIPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tipd_pkg.sv @@
// shared types and constants of the tape pulse decoder
package tipd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CLK_W      = 24;
    localparam int unsigned RAW_LEN_W  = 24;
    localparam int unsigned LEN_W      = 27;
    localparam int unsigned CYC_W      = 32;
    localparam int unsigned PROD_W     = LEN_W + CLK_W;
    localparam int unsigned DIV_STEPS  = PROD_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
    localparam int unsigned VER_W      = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [VER_W-1:0] VER_CYCLES = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPE_CLK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMU_CLK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THR  = 2'd3;

    localparam logic [VER_W-1:0] RST_VERSION  = 2'd0;
    localparam logic [CLK_W-1:0] RST_TAPE_CLK = 24'd985248;
    localparam logic [CLK_W-1:0] RST_EMU_CLK  = 24'd985248;
    localparam logic [CYC_W-1:0] RST_GAP_THR  = 32'd1000000;

    localparam logic [1:0] LONG_BYTES = 2'd3;

    typedef struct packed {
        logic             has_pulse;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

@@ hw/rtl/tape_image_pulse_decoder_unit.sv @@
// an accepted pulse byte becomes a queued job, then passes the back end states multiply, divide and done
// into the output register; a new job is taken only in idle, and the 51-step divider makes one bit per cycle
// end markers go from idle straight to done, skipping multiply and divide; bytes without a result push no job
// the input side keeps accepting while the job queue has room
// reset: synchronous active low, clears control state and loads default clock rates
module tape_image_pulse_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [tipd_pkg::BYTE_W-1:0]       i_s_axis_tdata,   // [7:0] data_byte
    input  logic                              i_s_axis_tlast,   // end_of_data
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [tipd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,   // [0] has_pulse, [32:1] pulse_cycles, [33] is_gap
    output logic                              o_m_axis_tlast,   // last
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tipd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tipd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tipd_pkg::*;

    logic [VER_W-1:0] r_version;
    logic [CLK_W-1:0] r_tape_clk;
    logic [CLK_W-1:0] r_emu_clk;
    logic [CYC_W-1:0] r_gap_thr;
    logic             w_push;
    t_job             w_push_job;
    logic             w_not_full;
    logic             w_not_empty;
    t_job             w_head_job;
    logic             w_pop;
    logic             w_has;
    logic [CYC_W-1:0] w_cyc;
    logic             w_gap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version  <= RST_VERSION;
            r_tape_clk <= RST_TAPE_CLK;
            r_emu_clk  <= RST_EMU_CLK;
            r_gap_thr  <= RST_GAP_THR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VERSION:  r_version  <= i_cfg_data[VER_W-1:0];
                CFG_TAPE_CLK: r_tape_clk <= i_cfg_data[CLK_W-1:0];
                CFG_EMU_CLK:  r_emu_clk  <= i_cfg_data[CLK_W-1:0];
                CFG_GAP_THR:  r_gap_thr  <= i_cfg_data[CYC_W-1:0];
                default:      r_version  <= r_version;
            endcase
        end
    end

    tipd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_fin       (i_s_axis_tlast),
        .i_version   (r_version),
        .o_job_valid (w_push),
        .o_job       (w_push_job),
        .i_job_ready (w_not_full)
    );

    tipd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_push_job),
        .o_not_full  (w_not_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_job       (w_head_job)
    );

    tipd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_not_empty),
        .i_job          (w_head_job),
        .o_job_pop      (w_pop),
        .i_tape_clk     (r_tape_clk),
        .i_emu_clk      (r_emu_clk),
        .i_gap_thr      (r_gap_thr),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_has_pulse    (w_has),
        .o_pulse_cycles (w_cyc),
        .o_is_gap       (w_gap),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W-CYC_W-2){1'b0}}, w_gap, w_cyc, w_has};

endmodule

@@ hw/rtl/tipd_front.sv @@
// front end: long form assembly, version length scaling and job classification
module tipd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tipd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_fin,
    input  logic [tipd_pkg::VER_W-1:0]  i_version,
    output logic                        o_job_valid,
    output tipd_pkg::t_job              o_job,
    input  logic                        i_job_ready
);
    import tipd_pkg::*;

    logic                 r_active;
    logic [1:0]           r_seen;
    logic [RAW_LEN_W-1:0] r_acc;
    logic                 n_active;
    logic [1:0]           n_seen;
    logic [RAW_LEN_W-1:0] n_acc;
    logic [RAW_LEN_W-1:0] w_acc;
    logic [1:0]           w_seen;
    logic [RAW_LEN_W-1:0] w_len;
    logic                 w_done;
    logic                 w_pulse;
    logic                 w_accept;

    assign o_ready  = i_job_ready;
    assign w_accept = i_valid && i_job_ready;

    always_comb begin
        n_active = r_active;
        n_seen   = r_seen;
        n_acc    = r_acc;
        w_done   = 1'b0;
        w_len    = '0;
        w_acc    = r_acc;
        w_seen   = r_seen + 2'd1;
        unique case (r_seen)
            2'd0:    w_acc[7:0]   = i_byte;
            2'd1:    w_acc[15:8]  = i_byte;
            2'd2:    w_acc[23:16] = i_byte;
            default: w_acc        = r_acc;
        endcase
        if (r_active) begin
            if (w_seen == LONG_BYTES) begin
                w_len    = w_acc;
                w_done   = 1'b1;
                n_active = 1'b0;
                n_seen   = '0;
                n_acc    = '0;
            end else begin
                n_seen = w_seen;
                n_acc  = w_acc;
            end
        end else if (i_byte != '0) begin
            w_len  = {{(RAW_LEN_W-BYTE_W){1'b0}}, i_byte};
            w_done = 1'b1;
        end else begin
            n_active = 1'b1;
            n_seen   = '0;
            n_acc    = '0;
        end
        if (i_fin) begin
            n_active = 1'b0;
            n_seen   = '0;
            n_acc    = '0;
        end
    end

    assign w_pulse         = w_done && (w_len != '0);
    assign o_job_valid     = w_accept && (w_pulse || i_fin);
    assign o_job.has_pulse = w_pulse;
    assign o_job.last      = i_fin;
    assign o_job.len       = (i_version < VER_CYCLES) ? {w_len, 3'b000}
                                                      : {3'b000, w_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_seen   <= '0;
            r_acc    <= '0;
        end else if (w_accept) begin
            r_active <= n_active;
            r_seen   <= n_seen;
            r_acc    <= n_acc;
        end
    end

endmodule

@@ hw/rtl/tipd_queue.sv @@
// short job queue between front and back end
`include "tape_image_pulse_decoder_unit_macros.svh"

module tipd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tipd_pkg::t_job i_job,
    output logic           o_not_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output tipd_pkg::t_job o_job
);
    import tipd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_not_full  = (r_count != FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TIPD_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count overflow")
    `TIPD_ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, o_not_full, "push into full queue")
    `TIPD_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow")

endmodule

@@ hw/rtl/tipd_back.sv @@
// back end: clock rescale by multiply and bit serial divide, output register
`include "tape_image_pulse_decoder_unit_macros.svh"

module tipd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  tipd_pkg::t_job                 i_job,
    output logic                           o_job_pop,
    input  logic [tipd_pkg::CLK_W-1:0]     i_tape_clk,
    input  logic [tipd_pkg::CLK_W-1:0]     i_emu_clk,
    input  logic [tipd_pkg::CYC_W-1:0]     i_gap_thr,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_has_pulse,
    output logic [tipd_pkg::CYC_W-1:0]     o_pulse_cycles,
    output logic                           o_is_gap,
    output logic                           o_last
);
    import tipd_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    t_back_state        r_state;
    t_back_state        n_state;
    logic               r_has;
    logic               r_last;
    logic [LEN_W-1:0]   r_len;
    logic [CLK_W-1:0]   r_div;
    logic [PROD_W-1:0]  r_prod;
    logic [CLK_W-1:0]   r_rem;
    logic [CYC_W-1:0]   r_quo;
    logic               r_qnz;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_out_valid;
    logic               r_out_has;
    logic [CYC_W-1:0]   r_out_cyc;
    logic               r_out_gap;
    logic               r_out_last;
    logic               w_load_out;
    logic [CLK_W:0]     w_trial;
    logic [CLK_W:0]     w_diff;
    logic               w_ge;
    logic [CYC_W-1:0]   w_cyc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.has_pulse ? BK_MUL : BK_DONE;
                end
            end
            BK_MUL: n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = (r_state == BK_IDLE) && i_job_valid;
        w_load_out = (r_state == BK_DONE) && (!r_out_valid || i_ready);
    end

    assign w_trial = {r_rem, r_prod[PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_cyc   = r_has ? (r_qnz ? r_quo : CYC_W'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_has  <= i_job.has_pulse;
            r_last <= i_job.last;
            r_len  <= i_job.len;
            r_div  <= (i_tape_clk == '0) ? CLK_W'(1) : i_tape_clk;
        end
        if (r_state == BK_MUL) begin
            r_prod <= PROD_W'(r_len) * PROD_W'(i_emu_clk) + PROD_W'(r_div >> 1);
            r_rem  <= '0;
            r_quo  <= '0;
            r_qnz  <= 1'b0;
        end else if (r_state == BK_DIV) begin
            r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[CLK_W-1:0] : w_trial[CLK_W-1:0];
            r_quo  <= {r_quo[CYC_W-2:0], w_ge};
            r_qnz  <= r_qnz | w_ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == BK_DIV) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_has  <= r_has;
            r_out_cyc  <= w_cyc;
            r_out_gap  <= r_has && (w_cyc > i_gap_thr);
            r_out_last <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_has_pulse    = r_out_has;
    assign o_pulse_cycles = r_out_cyc;
    assign o_is_gap       = r_out_gap;
    assign o_last         = r_out_last;

    `TIPD_ASSERT_IMPLIES(a_rem_below_div, i_clk, i_rst_n, r_state == BK_DIV,
        r_rem < r_div, "remainder not below divisor")
    `TIPD_ASSERT_IMPLIES(a_step_bound, i_clk, i_rst_n, r_state == BK_DIV,
        r_cnt <= LAST_STEP, "divide ran too long")
    `TIPD_ASSERT_IMPLIES(a_marker_empty, i_clk, i_rst_n, r_out_valid && !r_out_has,
        (r_out_cyc == '0) && !r_out_gap, "end marker carries pulse data")

endmodule
